[hw/rtl/simple_machine_instruction_step_macros.svh]
// assertion macros used by the checker file
// no dependencies; expects clk_i and rst_ni in the module that uses them
`ifndef SIMPLE_MACHINE_INSTRUCTION_STEP_MACROS_SVH
`define SIMPLE_MACHINE_INSTRUCTION_STEP_MACROS_SVH

// property that must hold at every edge outside reset
`define SMIS_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SMIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/smis_pkg.sv]
// shared types and constants of the instruction step machine
// no dependencies; used by smis_ctrl, smis_dp and the top level
package smis_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int REG_COUNT = 16;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int REG_AW    = $clog2(REG_COUNT);

  typedef logic [MEM_AW-1:0] mem_addr_t;
  typedef logic [7:0]        byte_t;
  typedef logic [15:0]       word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  // opcodes in the high nibble of the first instruction byte
  localparam logic [3:0] OP_LOAD_MEM = 4'h1;
  localparam logic [3:0] OP_LOAD_IMM = 4'h2;
  localparam logic [3:0] OP_STORE    = 4'h3;
  localparam logic [3:0] OP_MOVE     = 4'h4;
  localparam logic [3:0] OP_ADD      = 4'h5;
  localparam logic [3:0] OP_JUMP_EQ  = 4'hB;
  localparam logic [3:0] OP_HALT     = 4'hC;

  // action codes of an input beat
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // memory read address source
  typedef enum logic [1:0] {
    ADDR_PC      = 2'd0,
    ADDR_PC_NEXT = 2'd1,
    ADDR_OPND    = 2'd2
  } mem_addr_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic          load_wr;
    logic          mem_rd;
    mem_addr_sel_e mem_sel;
    logic          ir0_ld;
    logic          ir1_ld;
    logic          rf_rd;
    logic          rf_sel_b;
    logic          opa_ld;
    logic          commit;
    logic          out_ld;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stopped;
    logic out_busy;
  } dp_status_t;

endpackage

[hw/rtl/smis_dp.sv]
// datapath: program memory, register file, pc, instruction execute, result register
// depends on smis_pkg
module smis_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smis_pkg::ctrl_cmd_t   cmd_i,
  output smis_pkg::dp_status_t  status_o,
  input  logic [7:0]            load_address_i,
  input  logic [7:0]            load_byte_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            pc_after_o,
  output logic                  screen_valid_o,
  output logic [15:0]           screen_value_o,
  output logic                  halted_flag_o
);
  import smis_pkg::*;

  byte_t              mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_q;
  byte_t              mem_rdata_q;
  word_t              rf_q [REG_COUNT];
  word_t              rf_rdata_q;
  mem_addr_t          pc_q;
  logic               stopped_q;
  byte_t              ir0_q;
  byte_t              ir1_q;
  word_t              opa_q;

  logic               out_valid_q;
  mem_addr_t          out_pc_q;
  logic               out_scr_v_q;
  word_t              out_scr_val_q;
  logic               out_halt_q;

  logic [3:0]         op;
  mem_addr_t          mem_raddr;
  reg_idx_t           rf_raddr;
  logic               mem_we;
  mem_addr_t          mem_waddr;
  byte_t              mem_wdata;

  logic               rf_we;
  reg_idx_t           rf_waddr;
  word_t              rf_wdata;
  logic               mem_st;
  logic               scr_v;
  word_t              scr_val;
  mem_addr_t          pc_next;
  logic               stopped_d;
  word_t              sum;
  logic               ovf;

  assign op = ir0_q[7:4];

  // memory read address select
  always_comb begin
    case (cmd_i.mem_sel)
      ADDR_PC:      mem_raddr = pc_q;
      ADDR_PC_NEXT: mem_raddr = pc_q + mem_addr_t'(1);
      ADDR_OPND:    mem_raddr = mem_rdata_q;
      default:      mem_raddr = pc_q;
    endcase
  end

  // register read address: first operand while second byte is on the read bus
  always_comb begin
    if (!cmd_i.rf_sel_b) begin
      if (op == OP_MOVE || op == OP_ADD) begin
        rf_raddr = mem_rdata_q[7:4];
      end else begin
        rf_raddr = ir0_q[3:0];
      end
    end else begin
      if (op == OP_ADD) begin
        rf_raddr = ir1_q[3:0];
      end else begin
        rf_raddr = '0;
      end
    end
  end

  // add of the two operands; a signed overflow saturates the result to all ones
  assign sum = opa_q + rf_rdata_q;
  assign ovf = (opa_q[15] == rf_rdata_q[15]) && (sum[15] != opa_q[15]);

  // instruction decode and execute
  always_comb begin
    rf_we     = 1'b0;
    rf_waddr  = ir0_q[3:0];
    rf_wdata  = '0;
    mem_st    = 1'b0;
    scr_v     = 1'b0;
    scr_val   = '0;
    pc_next   = pc_q + mem_addr_t'(2);
    stopped_d = stopped_q;
    unique case (op)
      OP_LOAD_MEM: begin
        rf_we    = 1'b1;
        rf_wdata = {8'h00, mem_rdata_q};
      end
      OP_LOAD_IMM: begin
        rf_we    = 1'b1;
        rf_wdata = {8'h00, ir1_q};
      end
      OP_STORE: begin
        if (ir1_q == '0) begin
          scr_v   = 1'b1;
          scr_val = opa_q;
        end else begin
          mem_st = 1'b1;
        end
      end
      OP_MOVE: begin
        rf_we    = 1'b1;
        rf_waddr = ir1_q[3:0];
        rf_wdata = opa_q;
      end
      OP_ADD: begin
        rf_we    = 1'b1;
        rf_wdata = ovf ? 16'hFFFF : sum;
      end
      OP_JUMP_EQ: begin
        if (opa_q == rf_rdata_q) begin
          pc_next = ir1_q;
        end
      end
      OP_HALT: begin
        stopped_d = 1'b1;
        pc_next   = pc_q;
      end
      default: begin
      end
    endcase
  end

  // memory write port: load beat or store instruction
  assign mem_we    = cmd_i.load_wr | (cmd_i.commit & mem_st);
  assign mem_waddr = cmd_i.load_wr ? load_address_i : ir1_q;
  assign mem_wdata = cmd_i.load_wr ? load_byte_i : opa_q[7:0];

  // memory array and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      mem_rdata_q <= mem_vld_q[mem_raddr] ? mem_q[mem_raddr] : '0;
    end
  end

  // written marks, unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (mem_we) begin
      mem_vld_q[mem_waddr] <= 1'b1;
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else if (cmd_i.commit && rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
  end

  // operand and instruction registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rf_rd) begin
      rf_rdata_q <= rf_q[rf_raddr];
    end
    if (cmd_i.ir0_ld) begin
      ir0_q <= mem_rdata_q;
    end
    if (cmd_i.ir1_ld) begin
      ir1_q <= mem_rdata_q;
    end
    if (cmd_i.opa_ld) begin
      opa_q <= rf_rdata_q;
    end
  end

  // architectural pc and halt state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      stopped_q <= 1'b0;
    end else if (cmd_i.commit) begin
      pc_q      <= pc_next;
      stopped_q <= stopped_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      if (cmd_i.commit) begin
        out_pc_q      <= pc_next;
        out_scr_v_q   <= scr_v;
        out_scr_val_q <= scr_val;
        out_halt_q    <= stopped_d;
      end else begin
        out_pc_q      <= pc_q;
        out_scr_v_q   <= 1'b0;
        out_scr_val_q <= '0;
        out_halt_q    <= stopped_q;
      end
    end
  end

  assign status_o.stopped  = stopped_q;
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign pc_after_o     = out_pc_q;
  assign screen_valid_o = out_scr_v_q;
  assign screen_value_o = out_scr_val_q;
  assign halted_flag_o  = out_halt_q;

endmodule

[hw/rtl/smis_ctrl.sv]
// controller: sequences a load write, or the fetch, operand reads and execute of a step beat
// depends on smis_pkg
module smis_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  smis_pkg::dp_status_t  status_i,
  output smis_pkg::ctrl_cmd_t   cmd_o
);
  import smis_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FETCH0 = 6'b000010,
    ST_FETCH1 = 6'b000100,
    ST_OPA    = 6'b001000,
    ST_EXEC   = 6'b010000,
    ST_DONE   = 6'b100000
  } ctrl_state_e;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            cmd_o.load_wr = 1'b1;
            state_d       = ST_DONE;
          end else if (status_i.stopped) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.mem_rd  = 1'b1;
            cmd_o.mem_sel = ADDR_PC;
            state_d       = ST_FETCH0;
          end
        end
      end
      ST_FETCH0: begin
        cmd_o.ir0_ld  = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        cmd_o.mem_sel = ADDR_PC_NEXT;
        state_d       = ST_FETCH1;
      end
      ST_FETCH1: begin
        cmd_o.ir1_ld   = 1'b1;
        cmd_o.mem_rd   = 1'b1;
        cmd_o.mem_sel  = ADDR_OPND;
        cmd_o.rf_rd    = 1'b1;
        cmd_o.rf_sel_b = 1'b0;
        state_d        = ST_OPA;
      end
      ST_OPA: begin
        cmd_o.opa_ld   = 1'b1;
        cmd_o.rf_rd    = 1'b1;
        cmd_o.rf_sel_b = 1'b1;
        state_d        = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/simple_machine_instruction_step.sv]
// top level of the instruction step machine: controller plus datapath
// depends on smis_pkg, smis_ctrl, smis_dp
//
//   channel | direction | handshake            | beat fields
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | action, load_address, load_byte
//   out     | output    | out_valid_o/out_ready_i | pc_after, screen_valid, screen_value,
//           |           |                      | halted_flag
//
// a step beat goes from accept through fetch0, fetch1, opa and exec: two fetch reads and one
// data read on the single memory port, two register file reads, then execute, which loads the result
// a load beat, or a step while halted, goes from accept to done, where it loads its result
// one beat in flight at a time; a new beat is taken while the previous result waits
// a stalled result holds execute until the result register frees
// reset clears pc, halt, registers and memory written marks at once; no sweep
module simple_machine_instruction_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  load_address_i,
  input  logic [7:0]  load_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pc_after_o,
  output logic        screen_valid_o,
  output logic [15:0] screen_value_o,
  output logic        halted_flag_o
);
  import smis_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  smis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // memory, registers and execute
  smis_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .load_address_i (load_address_i),
    .load_byte_i    (load_byte_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .pc_after_o     (pc_after_o),
    .screen_valid_o (screen_valid_o),
    .screen_value_o (screen_value_o),
    .halted_flag_o  (halted_flag_o)
  );

endmodule

[hw/rtl/smis_checker.sv]
// port level checker for the instruction step machine, bound to the top level
// depends on simple_machine_instruction_step_macros.svh
`include "simple_machine_instruction_step_macros.svh"

module smis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  pc_after_o,
  input logic        screen_valid_o,
  input logic [15:0] screen_value_o,
  input logic        halted_flag_o
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending_q;
  logic       halt_seen_q;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // beats accepted but not yet delivered, and sticky halt seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      halt_seen_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire && halted_flag_o) begin
        halt_seen_q <= 1'b1;
      end
    end
  end

  `SMIS_ASSERT_HOLDS(a_no_spurious_result, out_valid_o |-> (pending_q != 2'd0), "result without accepted beat")
  `SMIS_ASSERT_HOLDS(a_pending_bound, in_fire |-> (pending_q != 2'd2), "too many beats in flight")
  `SMIS_ASSERT_HOLDS(a_screen_idle_zero, (out_valid_o && !screen_valid_o) |-> (screen_value_o == 16'd0), "screen value without screen beat")
  `SMIS_ASSERT_HOLDS(a_halt_sticky, (out_valid_o && halt_seen_q) |-> halted_flag_o, "halt flag dropped")
  `SMIS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pc_after_o), "stalled result changed")

endmodule

bind simple_machine_instruction_step smis_checker u_smis_checker (.*);
